>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL files, included by the sampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define PDS_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) cond) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define PDS_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) pre |=> post) else $error(msg);

`endif

>>> rtl/core/pds_pkg.sv
package pds_pkg;

   localparam logic [14:0] SEED_COORD = 15'd12288;
   localparam logic signed [17:0] MARGIN_LO = 18'sd164;
   localparam logic signed [17:0] MARGIN_HI = 18'sd24412;
   localparam logic [23:0] RECIP_100 = 24'd10737419;
   localparam int RECIP_SHIFT = 30;

   localparam logic [2:0] ST_SEEDED    = 3'd0;
   localparam logic [2:0] ST_ACCEPTED  = 3'd1;
   localparam logic [2:0] ST_OUT_AREA  = 3'd2;
   localparam logic [2:0] ST_TOO_CLOSE = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_EXHAUSTED = 3'd5;

   localparam logic [2:0] REG_RADIUS        = 3'd0;
   localparam logic [2:0] REG_MIN_DIST_SQ   = 3'd1;
   localparam logic [2:0] REG_INV_CELL_SIZE = 3'd2;
   localparam logic [2:0] REG_GRID_COLS     = 3'd3;
   localparam logic [2:0] REG_GRID_ROWS     = 3'd4;
   localparam logic [2:0] REG_MAX_POINTS    = 3'd5;

   typedef struct packed {
      logic [2:0]  status;
      logic [14:0] point_x;
      logic [14:0] point_y;
      logic [11:0] point_index;
      logic [11:0] source_index;
   } rsp_type;

   function automatic logic [14:0] quarter_sin(input logic [4:0] idx);
      logic [14:0] v;
      unique case (idx)
         5'd0:  v = 15'd0;
         5'd1:  v = 15'd1029;
         5'd2:  v = 15'd2053;
         5'd3:  v = 15'd3070;
         5'd4:  v = 15'd4075;
         5'd5:  v = 15'd5063;
         5'd6:  v = 15'd6031;
         5'd7:  v = 15'd6976;
         5'd8:  v = 15'd7893;
         5'd9:  v = 15'd8779;
         5'd10: v = 15'd9630;
         5'd11: v = 15'd10444;
         5'd12: v = 15'd11216;
         5'd13: v = 15'd11943;
         5'd14: v = 15'd12624;
         5'd15: v = 15'd13255;
         5'd16: v = 15'd13833;
         5'd17: v = 15'd14357;
         5'd18: v = 15'd14825;
         5'd19: v = 15'd15233;
         5'd20: v = 15'd15582;
         5'd21: v = 15'd15869;
         5'd22: v = 15'd16094;
         5'd23: v = 15'd16255;
         5'd24: v = 15'd16352;
         5'd25: v = 15'd16384;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

   // Returns the sign in the top bit and the magnitude of sin(2*pi*s/100) below it.
   function automatic logic [15:0] trig_lookup(input logic [6:0] s);
      logic [1:0] q;
      logic [4:0] m;
      logic [4:0] idx;
      if (s >= 7'd75) begin
         q = 2'd3;
         m = 5'(s - 7'd75);
      end else if (s >= 7'd50) begin
         q = 2'd2;
         m = 5'(s - 7'd50);
      end else if (s >= 7'd25) begin
         q = 2'd1;
         m = 5'(s - 7'd25);
      end else begin
         q = 2'd0;
         m = 5'(s);
      end
      idx = q[0] ? 5'(5'd25 - m) : m;
      return {q[1], quarter_sin(idx)};
   endfunction

   function automatic logic [6:0] mod100(input logic [6:0] v);
      return (v >= 7'd100) ? 7'(v - 7'd100) : v;
   endfunction

endpackage

>>> rtl/core/pds_ifs.sv
interface pds_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [6:0] angle_step;
   logic [6:0] radius_step;
   modport source(output valid, opcode, angle_step, radius_step, input ready);
   modport sink(input valid, opcode, angle_step, radius_step, output ready);
endinterface

interface pds_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [14:0] point_x;
   logic [14:0] point_y;
   logic [11:0] point_index;
   logic [11:0] source_index;
   modport source(output valid, status, point_x, point_y, point_index, source_index,
                  input ready);
   modport sink(input valid, status, point_x, point_y, point_index, source_index,
                output ready);
endinterface

interface pds_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [28:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/core/pds_ram.sv
module pds_ram #(
   parameter int AW = 12,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/pds_dist.sv
module pds_dist (
   input  logic        clock,
   input  logic        reset,
   input  logic        vld,
   input  logic [15:0] px,
   input  logic [15:0] py,
   input  logic [14:0] cx,
   input  logic [14:0] cy,
   input  logic [28:0] min_dist_sq,
   output logic        hit
);

   logic signed [16:0] ex;
   logic signed [16:0] ey;
   logic [31:0] sqx_ff, sqx_in;
   logic [31:0] sqy_ff, sqy_in;
   logic vld_ff, vld_in;

   always_comb begin
      ex = $signed({1'b0, px}) - $signed({2'b0, cx});
      ey = $signed({1'b0, py}) - $signed({2'b0, cy});
      sqx_in = 32'(ex * ex);
      sqy_in = 32'(ey * ey);
      vld_in = vld;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
   end

   assign hit = vld_ff && ((33'(sqx_ff) + 33'(sqy_ff)) < 33'(min_dist_sq));

endmodule

>>> rtl/core/poisson_disk_dart_sampler.sv
// Channel  Direction  Transfer carries
// req_ch   in         opcode, angle_step, radius_step
// rsp_ch   out        status, point_x, point_y, point_index, source_index
// csr_ch   in         register index and write data, always ready
//
// A candidate that keeps its source runs setup, then 25 neighborhood cells one a cycle
// through the cell grid and point store memories, a drain and the decision; one that
// reads a new source first fetches that source from the point store.
// A dart outside the margin answers after the margin check and an exhausted queue from idle.
// A start clears all GRID_SIDE*GRID_SIDE cell grid entries one entry a cycle, then writes
// the seed and returns its result. The same clearing pass runs after reset.
// A new item is taken while a result waits; the block stalls in its last state when a
// second result is due before the first one is transferred.
`include "assert_macros.svh"

module poisson_disk_dart_sampler #(
   parameter int MAX_POINTS = 4096,
   parameter int GRID_SIDE = 64,
   parameter int TRIES_PER_SOURCE = 100
) (
   input logic clock,
   input logic reset,
   pds_req_if.sink   req_ch,
   pds_rsp_if.source rsp_ch,
   pds_csr_if.sink   csr_ch
);

   localparam int PIDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int LIM_W = (CNT_W > 13) ? CNT_W : 13;
   localparam int TC_W = $clog2(TRIES_PER_SOURCE + 1);
   localparam int GA_W = $clog2(GRID_SIDE * GRID_SIDE);
   localparam int CI_W = $clog2(GRID_SIDE);
   localparam int GC_W = $clog2(GRID_SIDE + 1);
   localparam int GCW = (GC_W > 7) ? GC_W : 7;
   localparam int CMPW = (GCW > 8) ? GCW : 8;
   localparam int XW = (CI_W + 2 > GCW) ? CI_W + 2 : GCW;
   localparam int GE_W = PIDX_W + 1;

   typedef enum logic [17:0] {
      S_CLEAR    = 18'b000000000000000001,
      S_IDLE     = 18'b000000000000000010,
      S_SEED_MUL = 18'b000000000000000100,
      S_SEED_WR  = 18'b000000000000001000,
      S_SRC      = 18'b000000000000010000,
      S_DR       = 18'b000000000000100000,
      S_DQ       = 18'b000000000001000000,
      S_OFFX     = 18'b000000000010000000,
      S_OFFY     = 18'b000000000100000000,
      S_POSY     = 18'b000000001000000000,
      S_CHECK    = 18'b000000010000000000,
      S_CELLX    = 18'b000000100000000000,
      S_CELLY    = 18'b000001000000000000,
      S_CELLJ    = 18'b000010000000000000,
      S_SCAN     = 18'b000100000000000000,
      S_DRAIN    = 18'b001000000000000000,
      S_DECIDE   = 18'b010000000000000000,
      S_EMIT     = 18'b100000000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [14:0] radius_ff, radius_in;
   logic [28:0] min_dist_sq_ff, min_dist_sq_in;
   logic [15:0] inv_cell_ff, inv_cell_in;
   logic [6:0]  grid_cols_ff, grid_cols_in;
   logic [6:0]  grid_rows_ff, grid_rows_in;
   logic [12:0] max_points_ff, max_points_in;

   logic [GA_W-1:0]  clr_ff, clr_in;
   logic             seed_pending_ff, seed_pending_in;
   logic [CNT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] tail_ff, tail_in;
   logic [TC_W-1:0]  try_ff, try_in;
   logic [15:0]      src_x_ff, src_x_in;
   logic [15:0]      src_y_ff, src_y_in;
   logic [6:0]       as_ff, as_in;
   logic [6:0]       rs_ff, rs_in;
   logic [22:0]      drp_ff, drp_in;
   logic [15:0]      dr_ff, dr_in;
   logic [31:0]      prod_ff, prod_in;
   logic signed [17:0] nx_ff, nx_in;
   logic signed [17:0] ny_ff, ny_in;
   logic [CI_W-1:0]  ci_ff, ci_in;
   logic [CI_W-1:0]  cj_ff, cj_in;
   logic [2:0]       di_ff, di_in;
   logic [2:0]       dj_ff, dj_in;
   logic [1:0]       drain_ff, drain_in;
   logic             s1_vld_ff, s1_vld_in;
   logic             s2_vld_ff, s2_vld_in;
   logic             hit_ff, hit_in;
   pds_pkg::rsp_type res_ff, res_in;
   pds_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [15:0] mul_a;
   logic [15:0] mul_b;
   logic [LIM_W-1:0] limit;
   logic [LIM_W-1:0] maxp;
   logic [GCW-1:0] cols;
   logic [GCW-1:0] rows;
   logic [15:0] cos_t;
   logic [15:0] sin_t;
   logic [6:0]  cos_s;
   logic [XW-1:0] ti;
   logic [XW-1:0] tj;
   logic nb_ok;
   logic [GA_W-1:0] nb_addr;
   logic [CI_W-1:0] seed_cx;
   logic [CI_W-1:0] seed_cy;
   logic [TC_W-1:0] try_next;
   logic [11:0] sidx;
   logic req_fire;

   logic            grid_we;
   logic [GA_W-1:0] grid_waddr;
   logic [GE_W-1:0] grid_wdata;
   logic            grid_re;
   logic [GE_W-1:0] grid_rdata;
   logic              pt_we;
   logic [PIDX_W-1:0] pt_waddr;
   logic [31:0]       pt_wdata;
   logic              pt_re;
   logic [PIDX_W-1:0] pt_raddr;
   logic [31:0]       pt_rdata;
   logic              dist_hit;

   function automatic logic [CI_W-1:0] clamp_cell(input logic [7:0] c,
                                                 input logic [GCW-1:0] cnt);
      logic [GCW-1:0] last;
      last = GCW'(cnt - 1'b1);
      return (CMPW'(c) > CMPW'(last)) ? CI_W'(last) : CI_W'(c);
   endfunction

   function automatic logic [GCW-1:0] clamp_count(input logic [6:0] v);
      logic [GCW-1:0] w;
      w = GCW'(v);
      if (w == '0) begin
         return GCW'(1);
      end else if (w > GCW'(GRID_SIDE)) begin
         return GCW'(GRID_SIDE);
      end
      return w;
   endfunction

   function automatic logic [GA_W-1:0] cell_addr(input logic [CI_W-1:0] x,
                                                input logic [CI_W-1:0] y,
                                                input logic [GCW-1:0] c);
      return GA_W'(GA_W'(x) + GA_W'(GA_W'(y) * GA_W'(c)));
   endfunction

   function automatic logic signed [17:0] add_offset(input logic [15:0] base,
                                                    input logic [31:0] p,
                                                    input logic neg);
      logic [16:0] off;
      off = 17'((p + 32'd8192) >> 14);
      return neg ? ($signed({2'b0, base}) - $signed({1'b0, off}))
                 : ($signed({2'b0, base}) + $signed({1'b0, off}));
   endfunction

   pds_ram #(.AW(GA_W), .DW(GE_W)) u_cell_grid (
      .clock(clock),
      .we(grid_we),
      .waddr(grid_waddr),
      .wdata(grid_wdata),
      .re(grid_re),
      .raddr(nb_addr),
      .rdata(grid_rdata)
   );

   pds_ram #(.AW(PIDX_W), .DW(32)) u_point_store (
      .clock(clock),
      .we(pt_we),
      .waddr(pt_waddr),
      .wdata(pt_wdata),
      .re(pt_re),
      .raddr(pt_raddr),
      .rdata(pt_rdata)
   );

   pds_dist u_dist (
      .clock(clock),
      .reset(reset),
      .vld(s2_vld_ff),
      .px(pt_rdata[15:0]),
      .py(pt_rdata[31:16]),
      .cx(nx_ff[14:0]),
      .cy(ny_ff[14:0]),
      .min_dist_sq(min_dist_sq_ff),
      .hit(dist_hit)
   );

   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   always_comb begin
      maxp = LIM_W'(max_points_ff);
      if (maxp == '0) begin
         limit = LIM_W'(1);
      end else if (maxp > LIM_W'(MAX_POINTS)) begin
         limit = LIM_W'(MAX_POINTS);
      end else begin
         limit = maxp;
      end
      cols = clamp_count(grid_cols_ff);
      rows = clamp_count(grid_rows_ff);
      cos_s = pds_pkg::mod100(7'(as_ff + 7'd25));
      cos_t = pds_pkg::trig_lookup(cos_s);
      sin_t = pds_pkg::trig_lookup(as_ff);
      ti = XW'(ci_ff) + XW'(di_ff);
      tj = XW'(cj_ff) + XW'(dj_ff);
      nb_ok = (ti >= XW'(2)) && (XW'(ti - XW'(2)) < XW'(cols))
           && (tj >= XW'(2)) && (XW'(tj - XW'(2)) < XW'(rows));
      nb_addr = cell_addr(CI_W'(ti - XW'(2)), CI_W'(tj - XW'(2)), cols);
      seed_cx = clamp_cell(prod_ff[31:24], cols);
      seed_cy = clamp_cell(prod_ff[31:24], rows);
      try_next = (32'(try_ff) + 32'd1 >= 32'(TRIES_PER_SOURCE)) ? '0 : TC_W'(try_ff + 1'b1);
      sidx = 12'(head_ff - 1'b1);
   end

   always_comb begin
      state_in = state_ff;
      radius_in = radius_ff;
      min_dist_sq_in = min_dist_sq_ff;
      inv_cell_in = inv_cell_ff;
      grid_cols_in = grid_cols_ff;
      grid_rows_in = grid_rows_ff;
      max_points_in = max_points_ff;
      clr_in = clr_ff;
      seed_pending_in = seed_pending_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      try_in = try_ff;
      src_x_in = src_x_ff;
      src_y_in = src_y_ff;
      as_in = as_ff;
      rs_in = rs_ff;
      drp_in = drp_ff;
      dr_in = dr_ff;
      nx_in = nx_ff;
      ny_in = ny_ff;
      ci_in = ci_ff;
      cj_in = cj_ff;
      di_in = di_ff;
      dj_in = dj_ff;
      drain_in = drain_ff;
      s1_vld_in = 1'b0;
      s2_vld_in = s1_vld_ff && grid_rdata[PIDX_W];
      hit_in = hit_ff | dist_hit;
      res_in = res_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      mul_a = '0;
      mul_b = '0;
      grid_we = 1'b0;
      grid_waddr = '0;
      grid_wdata = '0;
      grid_re = 1'b0;
      pt_we = 1'b0;
      pt_waddr = '0;
      pt_wdata = '0;
      pt_re = s1_vld_ff && grid_rdata[PIDX_W];
      pt_raddr = grid_rdata[PIDX_W-1:0];

      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            pds_pkg::REG_RADIUS:        radius_in = csr_ch.data[14:0];
            pds_pkg::REG_MIN_DIST_SQ:   min_dist_sq_in = csr_ch.data;
            pds_pkg::REG_INV_CELL_SIZE: inv_cell_in = csr_ch.data[15:0];
            pds_pkg::REG_GRID_COLS:     grid_cols_in = csr_ch.data[6:0];
            pds_pkg::REG_GRID_ROWS:     grid_rows_in = csr_ch.data[6:0];
            pds_pkg::REG_MAX_POINTS:    max_points_in = csr_ch.data[12:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            grid_we = 1'b1;
            grid_waddr = clr_ff;
            clr_in = GA_W'(clr_ff + 1'b1);
            if (clr_ff == GA_W'(GRID_SIDE * GRID_SIDE - 1)) begin
               state_in = seed_pending_ff ? S_SEED_MUL : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               as_in = pds_pkg::mod100(req_ch.angle_step);
               rs_in = pds_pkg::mod100(req_ch.radius_step);
               if (!req_ch.opcode) begin
                  seed_pending_in = 1'b1;
                  clr_in = '0;
                  state_in = S_CLEAR;
               end else if (try_ff != '0) begin
                  try_in = try_next;
                  state_in = S_DR;
               end else if ((LIM_W'(head_ff) < limit) && (head_ff < tail_ff)) begin
                  pt_re = 1'b1;
                  pt_raddr = PIDX_W'(head_ff);
                  state_in = S_SRC;
               end else begin
                  res_in = '{pds_pkg::ST_EXHAUSTED, 15'd0, 15'd0, 12'd0, 12'd0};
                  state_in = S_EMIT;
               end
            end
         end
         S_SEED_MUL: begin
            mul_a = {1'b0, pds_pkg::SEED_COORD};
            mul_b = inv_cell_ff;
            seed_pending_in = 1'b0;
            state_in = S_SEED_WR;
         end
         S_SEED_WR: begin
            grid_we = 1'b1;
            grid_waddr = cell_addr(seed_cx, seed_cy, cols);
            grid_wdata = {1'b1, PIDX_W'(0)};
            pt_we = 1'b1;
            pt_waddr = '0;
            pt_wdata = {1'b0, pds_pkg::SEED_COORD, 1'b0, pds_pkg::SEED_COORD};
            head_in = '0;
            tail_in = CNT_W'(1);
            try_in = '0;
            src_x_in = '0;
            src_y_in = '0;
            res_in = '{pds_pkg::ST_SEEDED, pds_pkg::SEED_COORD, pds_pkg::SEED_COORD,
                       12'd0, 12'd0};
            state_in = S_EMIT;
         end
         S_SRC: begin
            src_x_in = pt_rdata[15:0];
            src_y_in = pt_rdata[31:16];
            head_in = CNT_W'(head_ff + 1'b1);
            try_in = try_next;
            state_in = S_DR;
         end
         S_DR: begin
            drp_in = 23'(23'(radius_ff) * 23'(8'd100 + 8'(rs_ff)) + 23'd50);
            state_in = S_DQ;
         end
         S_DQ: begin
            dr_in = 16'((47'(drp_ff) * 47'(pds_pkg::RECIP_100)) >> pds_pkg::RECIP_SHIFT);
            state_in = S_OFFX;
         end
         S_OFFX: begin
            mul_a = {1'b0, cos_t[14:0]};
            mul_b = dr_ff;
            state_in = S_OFFY;
         end
         S_OFFY: begin
            nx_in = add_offset(src_x_ff, prod_ff, cos_t[15]);
            mul_a = {1'b0, sin_t[14:0]};
            mul_b = dr_ff;
            state_in = S_POSY;
         end
         S_POSY: begin
            ny_in = add_offset(src_y_ff, prod_ff, sin_t[15]);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if ((nx_ff > pds_pkg::MARGIN_LO) && (nx_ff < pds_pkg::MARGIN_HI)
                && (ny_ff > pds_pkg::MARGIN_LO) && (ny_ff < pds_pkg::MARGIN_HI)) begin
               state_in = S_CELLX;
            end else begin
               res_in = '{pds_pkg::ST_OUT_AREA, 15'd0, 15'd0, 12'd0, sidx};
               state_in = S_EMIT;
            end
         end
         S_CELLX: begin
            mul_a = 16'(nx_ff[15:0]);
            mul_b = inv_cell_ff;
            state_in = S_CELLY;
         end
         S_CELLY: begin
            ci_in = clamp_cell(prod_ff[31:24], cols);
            mul_a = 16'(ny_ff[15:0]);
            mul_b = inv_cell_ff;
            state_in = S_CELLJ;
         end
         S_CELLJ: begin
            cj_in = clamp_cell(prod_ff[31:24], rows);
            di_in = '0;
            dj_in = '0;
            hit_in = 1'b0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            grid_re = 1'b1;
            s1_vld_in = nb_ok;
            if (di_ff == 3'd4) begin
               di_in = '0;
               if (dj_ff == 3'd4) begin
                  drain_in = '0;
                  state_in = S_DRAIN;
               end else begin
                  dj_in = 3'(dj_ff + 1'b1);
               end
            end else begin
               di_in = 3'(di_ff + 1'b1);
            end
         end
         S_DRAIN: begin
            drain_in = 2'(drain_ff + 1'b1);
            if (drain_ff == 2'd2) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (hit_ff) begin
               res_in = '{pds_pkg::ST_TOO_CLOSE, 15'd0, 15'd0, 12'd0, sidx};
            end else if (LIM_W'(tail_ff) >= limit) begin
               res_in = '{pds_pkg::ST_FULL, 15'd0, 15'd0, 12'd0, sidx};
            end else begin
               pt_we = 1'b1;
               pt_waddr = PIDX_W'(tail_ff);
               pt_wdata = {ny_ff[15:0], nx_ff[15:0]};
               grid_we = 1'b1;
               grid_waddr = cell_addr(ci_ff, cj_ff, cols);
               grid_wdata = {1'b1, PIDX_W'(tail_ff)};
               tail_in = CNT_W'(tail_ff + 1'b1);
               res_in = '{pds_pkg::ST_ACCEPTED, nx_ff[14:0], ny_ff[14:0], 12'(tail_ff), sidx};
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      prod_in = 32'(mul_a) * 32'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         radius_ff <= 15'd1638;
         min_dist_sq_ff <= 29'd2684355;
         inv_cell_ff <= 16'd14482;
         grid_cols_ff <= 7'd21;
         grid_rows_ff <= 7'd21;
         max_points_ff <= 13'd225;
         clr_ff <= '0;
         seed_pending_ff <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
         try_ff <= '0;
         src_x_ff <= '0;
         src_y_ff <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         hit_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         radius_ff <= radius_in;
         min_dist_sq_ff <= min_dist_sq_in;
         inv_cell_ff <= inv_cell_in;
         grid_cols_ff <= grid_cols_in;
         grid_rows_ff <= grid_rows_in;
         max_points_ff <= max_points_in;
         clr_ff <= clr_in;
         seed_pending_ff <= seed_pending_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         try_ff <= try_in;
         src_x_ff <= src_x_in;
         src_y_ff <= src_y_in;
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         hit_ff <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      as_ff <= as_in;
      rs_ff <= rs_in;
      drp_ff <= drp_in;
      dr_ff <= dr_in;
      prod_ff <= prod_in;
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      ci_ff <= ci_in;
      cj_ff <= cj_in;
      di_ff <= di_in;
      dj_ff <= dj_in;
      drain_ff <= drain_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_ff.status;
   assign rsp_ch.point_x = rsp_ff.point_x;
   assign rsp_ch.point_y = rsp_ff.point_y;
   assign rsp_ch.point_index = rsp_ff.point_index;
   assign rsp_ch.source_index = rsp_ff.source_index;

   `PDS_ASSERT(a_head_within_tail, head_ff <= tail_ff, "Queue head passed queue tail.")
   `PDS_ASSERT(a_tail_bounded, tail_ff <= CNT_W'(MAX_POINTS), "Queue tail beyond store size.")
   `PDS_ASSERT_NEXT(a_accept_starts_work, req_ch.valid && req_ch.ready, state_ff != S_IDLE, "Accepted item did not start work.")
   `PDS_ASSERT_NEXT(a_emit_waits, (state_ff == S_EMIT) && rsp_valid_ff && !rsp_ch.ready, (state_ff == S_EMIT) && $stable(res_ff), "Result lost while output was stalled.")

endmodule
